// ----- rtl/w8u16_pkg.sv -----
// Shared types, constants and byte classification for the WTF-8 to UTF-16 decoder.
package w8u16_pkg;

  localparam logic [15:0] REPL_UNIT = 16'hFFFD;
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [20:0] SUPP_OFFSET = 21'h10000;
  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;
  localparam logic [7:0] E0_MIN_SECOND = 8'hA0;
  localparam logic [7:0] F0_MIN_SECOND = 8'h90;
  localparam logic [7:0] F4_MAX_SECOND = 8'h8F;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG = 8'h80;

  // Held bytes plus the incoming one.
  localparam int unsigned SLOTS = 4;

  typedef struct packed {
    logic load;     // append the accepted byte
    logic emit_hi;  // emit the high surrogate, keep the bytes
    logic emit;     // emit the head result and consume its bytes
  } w8u16_cmd_t;

  typedef struct packed {
    logic stop;      // nothing decodable at the head
    logic four;      // head is a valid four-byte sequence
    logic out_free;  // output register can take a result
  } w8u16_sts_t;

  // Sequence length of a lead byte; zero for a byte that cannot lead.
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    if (b <= 8'h7F) n = 3'd1;
    else if (b >= LEAD2_LO && b <= LEAD2_HI) n = 3'd2;
    else if (b >= LEAD3_LO && b <= LEAD3_HI) n = 3'd3;
    else if (b >= LEAD4_LO && b <= LEAD4_HI) n = 3'd4;
    return n;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & CONT_MASK) == CONT_TAG;
  endfunction

endpackage

// ----- rtl/w8u16_if.sv -----
// Stream interfaces for the decoder's byte input and code unit output.
interface w8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface w8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        was_error;
  logic        run_last;
  logic        string_done;

  modport source (output valid, output code_unit, output was_error, output run_last,
                  output string_done, input ready);
  modport sink (input valid, input code_unit, input was_error, input run_last,
                input string_done, output ready);
endinterface

// ----- rtl/w8u16_ctrl.sv -----
// Controller state machine: byte intake, result sequencing, surrogate pair phase.
module w8u16_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  w8u16_pkg::w8u16_sts_t sts_i,
  output w8u16_pkg::w8u16_cmd_t cmd_o
);
  import w8u16_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_PAIR = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    in_ready_o = 1'b0;
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.stop) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          if (sts_i.four) begin
            cmd_o.emit_hi = 1'b1;
            state_d = ST_PAIR;
          end else begin
            cmd_o.emit = 1'b1;
          end
        end
      end
      ST_PAIR: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_DECODE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/w8u16_dp.sv -----
// Datapath: held byte line, head sequence decode, lookahead and output register.
module w8u16_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            data_byte_i,
  input  logic                  final_byte_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [15:0]           code_unit_o,
  output logic                  was_error_o,
  output logic                  run_last_o,
  output logic                  string_done_o,
  input  w8u16_pkg::w8u16_cmd_t cmd_i,
  output w8u16_pkg::w8u16_sts_t sts_o
);
  import w8u16_pkg::*;

  logic [7:0]  hold_q [SLOTS];
  logic [2:0]  count_q;
  logic        fin_q;

  logic        out_valid_q;
  logic [15:0] unit_q;
  logic        err_q, last_q, done_q;

  logic [7:0]  b0, b1, b2, b3;
  logic [2:0]  n, used, rest, next_len;
  logic        ok, short, more;
  logic [20:0] cp;
  logic [15:0] single_unit, hi_unit, lo_unit, emit_unit;
  logic [7:0]  next_head;

  assign b0 = hold_q[0];
  assign b1 = hold_q[1];
  assign b2 = hold_q[2];
  assign b3 = hold_q[3];

  // Head decode: a sequence is judged only once all its bytes are in or the string ends.
  always_comb begin
    n = seq_len(b0);
    short = n > count_q;
    ok = (n != 3'd0) && !short;
    if (n >= 3'd2 && !is_cont(b1)) ok = 1'b0;
    if (n >= 3'd3 && !is_cont(b2)) ok = 1'b0;
    if (n == 3'd4 && !is_cont(b3)) ok = 1'b0;
    if (b0 == LEAD3_LO && b1 < E0_MIN_SECOND) ok = 1'b0;
    if (b0 == LEAD4_LO && b1 < F0_MIN_SECOND) ok = 1'b0;
    if (b0 == LEAD4_HI && b1 > F4_MAX_SECOND) ok = 1'b0;
    if (n == 3'd1) ok = 1'b1;
    used = ok ? n : 3'd1;
  end

  always_comb begin
    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]} - SUPP_OFFSET;
    hi_unit = HI_SURR_BASE + {6'd0, cp[19:10]};
    lo_unit = LO_SURR_BASE | {6'd0, cp[9:0]};
    case (n)
      3'd1: single_unit = {8'd0, b0};
      3'd2: single_unit = {5'd0, b0[4:0], b1[5:0]};
      3'd3: single_unit = {b0[3:0], b1[5:0], b2[5:0]};
      default: single_unit = REPL_UNIT;
    endcase
    if (!ok) single_unit = REPL_UNIT;
    emit_unit = (ok && n == 3'd4) ? lo_unit : single_unit;
  end

  // Lookahead: does the byte after this sequence yield another result in this run?
  always_comb begin
    rest = count_q - used;
    case (used)
      3'd1: next_head = b1;
      3'd2: next_head = b2;
      3'd3: next_head = b3;
      default: next_head = b0;
    endcase
    next_len = seq_len(next_head);
    more = (rest != 3'd0) && (fin_q || next_len <= rest);
  end

  assign sts_o.stop = (count_q == 3'd0) || (!fin_q && short);
  assign sts_o.four = ok && (n == 3'd4);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Held byte line: append on load, shift out consumed bytes on emit.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hold_q[count_q[1:0]] <= data_byte_i;
      fin_q <= final_byte_i;
    end else if (cmd_i.emit) begin
      case (used)
        3'd1: begin
          hold_q[0] <= b1;
          hold_q[1] <= b2;
          hold_q[2] <= b3;
        end
        3'd2: begin
          hold_q[0] <= b2;
          hold_q[1] <= b3;
        end
        3'd3: begin
          hold_q[0] <= b3;
        end
        default: begin
          hold_q[0] <= b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd0;
    end else if (cmd_i.load) begin
      count_q <= count_q + 3'd1;
    end else if (cmd_i.emit) begin
      count_q <= rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_hi) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_hi) begin
      unit_q <= hi_unit;
      err_q <= 1'b0;
      last_q <= 1'b0;
      done_q <= 1'b0;
    end else if (cmd_i.emit) begin
      unit_q <= emit_unit;
      err_q <= !ok;
      last_q <= !more;
      done_q <= !more && fin_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign code_unit_o = unit_q;
  assign was_error_o = err_q;
  assign run_last_o = last_q;
  assign string_done_o = done_q;

endmodule

// ----- rtl/wtf8_to_utf16_decoder_unit.sv -----
// Top level of the WTF-8 to UTF-16 decoder: controller, datapath and assertions.
//
//   channel | dir | payload                                        | handshake
//   in_i    | in  | data_byte[7:0], final_byte                     | valid/ready
//   out_o   | out | code_unit[15:0], was_error, run_last, string_done | valid/ready
//
// Flow: a request is taken in idle, then each result it causes is emitted in turn;
//   the controller returns to idle when nothing decodable is left, and only then
//   takes a new byte. The single head decoder yields a surrogate pair for four bytes.
// Reset: rst_ni clears the controller, the held count and the output valid.
// Stalls: a full output register that is not taken holds the decoder in place; a new
//   request is taken while the last result of the previous one still waits.
module wtf8_to_utf16_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  w8u16_in_if.sink    in_i,
  w8u16_out_if.source out_o
);
  import w8u16_pkg::*;

  w8u16_cmd_t cmd;
  w8u16_sts_t sts;
  logic       in_ready;

  // Sequence requests and results.
  w8u16_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold bytes, decode the head sequence and drive the output register.
  w8u16_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (in_i.data_byte),
    .final_byte_i  (in_i.final_byte),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .code_unit_o   (out_o.code_unit),
    .was_error_o   (out_o.was_error),
    .run_last_o    (out_o.run_last),
    .string_done_o (out_o.string_done),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

  assign in_i.ready = in_ready;

`ifndef SYNTHESIS
  // A taken request keeps the intake closed while its bytes are decoded.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request taken while previous one still decoding");

  // Never overwrite a result that is still waiting.
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit || cmd.emit_hi) |-> sts.out_free)
    else $error("result emitted into a full output register");

  // The high surrogate is followed by its low half before any new intake.
  a_pair_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_hi |=> !in_i.ready && !cmd.load)
    else $error("surrogate pair broken by new request");
`endif

endmodule
